### rtl/core/bsfs_pkg.sv
package bsfs_pkg;

    localparam int PAYLOAD_W     = 32;
    localparam int ADDR_W        = 6;
    localparam int KEY_W         = 3;
    localparam int LEN_FIELD_W   = 8;
    localparam int LEN_W         = 6;
    localparam int RUN_W         = 3;
    localparam int SHORT_LEN     = 8;
    localparam int DATA_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [RUN_W-1:0] STUFF_RUN = RUN_W'(4);

    localparam logic [3:0] START_PATTERN = 4'b1111;
    localparam logic [2:0] TRAIL_PATTERN = 3'b000;

    localparam int START_LEN = 4;
    localparam int KEY_LEN   = 3;
    localparam int ADDR_LEN  = 6;
    localparam int MARK_LEN  = 1;
    localparam int PAR_LEN   = 2;
    localparam int TRAIL_LEN = 3;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_KEY   = 3'd1,
        PH_ADDR  = 3'd2,
        PH_LEN   = 3'd3,
        PH_MARK  = 3'd4,
        PH_DATA  = 3'd5,
        PH_PAR   = 3'd6,
        PH_TRAIL = 3'd7
    } phase_t;

    typedef struct packed {
        logic                 send_request;
        logic [ADDR_W-1:0]    dev_address;
        logic [PAYLOAD_W-1:0] payload;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic request_taken;
        logic frame_last;
    } out_item_t;

    typedef struct packed {
        logic                 req;
        logic [KEY_W-1:0]     key;
        logic [ADDR_W-1:0]    addr;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     len;
        logic                 parity;
    } cls_item_t;

endpackage

### rtl/core/bit_stuffed_frame_serializer_core.sv
// Channel   Handshake        Payload                                 Per beat
// input     push / full      item: send_request, dev_address, payload  one bit period
// result    pop / empty      result: line_level, busy_res, request_taken, frame_last
// config    key_we           key_wdata: scramble_key                  one write
// One input beat and one result beat per cycle, sustained while the serializer does not stall.
// An accepted input beat goes into the intake queue; the serializer reads it from there and
// writes its result beat into the result queue, whose head is on the result ports.
// The serializer advances one bit period per beat; it stalls only when the intake queue
// is empty or the result queue is full.
// Reset clears the key, both queues and the frame state; the line reads idle high.
module bit_stuffed_frame_serializer_core #(
    parameter int DATA_BITS   = bsfs_pkg::DATA_BITS_DEF,
    parameter int QUEUE_DEPTH = bsfs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  bsfs_pkg::in_item_t          item,
    input  logic                        pop,
    output logic                        empty,
    output bsfs_pkg::out_item_t         result,
    input  logic                        key_we,
    input  logic [bsfs_pkg::KEY_W-1:0]  key_wdata
);
    import bsfs_pkg::*;

    localparam int CLS_W = $bits(cls_item_t);
    localparam int OUT_W = $bits(out_item_t);

    cls_item_t        cls_in;
    logic [CLS_W-1:0] cls_q;
    cls_item_t        cls_out;
    logic             mid_empty;
    out_item_t        back_result;
    logic [OUT_W-1:0] res_q;
    logic             res_full;
    logic             step;

    assign step    = ~mid_empty & ~res_full;
    assign cls_out = cls_item_t'(cls_q);
    assign result  = out_item_t'(res_q);

    bsfs_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_we    (key_we),
        .key_wdata (key_wdata),
        .item      (item),
        .cls       (cls_in)
    );

    bsfs_fifo #(
        .W     (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (cls_in),
        .full    (full),
        .rd_en   (step),
        .rd_data (cls_q),
        .empty   (mid_empty)
    );

    bsfs_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .entry  (cls_out),
        .result (back_result)
    );

    bsfs_fifo #(
        .W     (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (step),
        .wr_data (back_result),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_q),
        .empty   (empty)
    );

endmodule

### rtl/core/bsfs_fifo.sv
module bsfs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/core/bsfs_front.sv
module bsfs_front #(
    parameter int DATA_BITS = bsfs_pkg::DATA_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              key_we,
    input  logic [bsfs_pkg::KEY_W-1:0]        key_wdata,
    input  bsfs_pkg::in_item_t                item,
    output bsfs_pkg::cls_item_t               cls
);
    import bsfs_pkg::*;

    logic [KEY_W-1:0]     key_reg;
    logic [PAYLOAD_W-1:0] data_mask;
    logic [PAYLOAD_W-1:0] data;
    logic [PAYLOAD_W-1:0] scrambled;
    logic [PAYLOAD_W-1:0] keep;
    logic [LEN_W-1:0]     bit_len;

    always_comb
    begin
        for (int i = 0; i < PAYLOAD_W; i++)
        begin
            data_mask[i] = (i < DATA_BITS);
        end
        data = item.payload & data_mask;

        bit_len = '0;
        for (int i = 0; i < PAYLOAD_W; i++)
        begin
            if (data[i])
            begin
                bit_len = LEN_W'(i + 1);
            end
        end

        if (bit_len <= LEN_W'(SHORT_LEN))
        begin
            scrambled = PAYLOAD_W'(data[SHORT_LEN-1:0] ^ SHORT_LEN'(key_reg));
        end
        else
        begin
            scrambled = data;
        end

        for (int i = 0; i < PAYLOAD_W; i++)
        begin
            keep[i] = (LEN_W'(i) < bit_len);
        end

        cls.req     = item.send_request;
        cls.key     = key_reg;
        cls.addr    = item.dev_address;
        cls.payload = scrambled;
        cls.len     = bit_len;
        cls.parity  = ^(scrambled & keep);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (key_we)
        begin
            key_reg <= key_wdata;
        end
    end

endmodule

### rtl/core/bsfs_back.sv
module bsfs_back #(
    parameter int DATA_BITS = bsfs_pkg::DATA_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  bsfs_pkg::cls_item_t  entry,
    output bsfs_pkg::out_item_t  result
);
    import bsfs_pkg::*;

    localparam int PAY_W = (DATA_BITS < PAYLOAD_W) ? DATA_BITS : PAYLOAD_W;
    localparam int FV_W  = (PAY_W > LEN_FIELD_W) ? PAY_W : LEN_FIELD_W;
    localparam int IDX_W = $clog2(FV_W + 1);
    localparam int SEL_W = $clog2(FV_W);

    logic                 sending_reg, sending_next, sending_e;
    phase_t               phase_reg, phase_next, phase_e;
    logic [IDX_W-1:0]     idx_reg, idx_next, idx_e;
    logic [RUN_W-1:0]     run_reg, run_next, run_e;
    logic                 stuff_reg, stuff_next, stuff_e;
    logic [KEY_W-1:0]     key_reg, key_next, key_e;
    logic [ADDR_W-1:0]    addr_reg, addr_next, addr_e;
    logic [PAY_W-1:0]     pay_reg, pay_next, pay_e;
    logic [LEN_W-1:0]     len_reg, len_next, len_e;
    logic                 par_reg, par_next, par_e;

    logic                 taken;
    logic [IDX_W-1:0]     flen;
    logic [FV_W-1:0]      fval;
    logic [IDX_W-1:0]     pos;
    logic                 bit_val;

    always_comb
    begin
        taken     = step & entry.req & ~sending_reg;
        sending_e = sending_reg | taken;
        phase_e   = taken ? PH_START : phase_reg;
        idx_e     = taken ? '0 : idx_reg;
        run_e     = taken ? '0 : run_reg;
        stuff_e   = taken ? 1'b0 : stuff_reg;
        key_e     = taken ? entry.key : key_reg;
        addr_e    = taken ? entry.addr : addr_reg;
        pay_e     = taken ? entry.payload[PAY_W-1:0] : pay_reg;
        len_e     = taken ? entry.len : len_reg;
        par_e     = taken ? entry.parity : par_reg;
    end

    always_comb
    begin
        unique case (phase_e)
            PH_START:
            begin
                flen = IDX_W'(START_LEN);
                fval = FV_W'(START_PATTERN);
            end
            PH_KEY:
            begin
                flen = IDX_W'(KEY_LEN);
                fval = FV_W'(key_e);
            end
            PH_ADDR:
            begin
                flen = IDX_W'(ADDR_LEN);
                fval = FV_W'(addr_e);
            end
            PH_LEN:
            begin
                flen = IDX_W'(LEN_FIELD_W);
                fval = FV_W'(len_e);
            end
            PH_MARK:
            begin
                flen = IDX_W'(MARK_LEN);
                fval = FV_W'(1'b1);
            end
            PH_DATA:
            begin
                flen = IDX_W'(len_e);
                fval = FV_W'(pay_e);
            end
            PH_PAR:
            begin
                flen = IDX_W'(PAR_LEN);
                fval = FV_W'(par_e);
            end
            PH_TRAIL:
            begin
                flen = IDX_W'(TRAIL_LEN);
                fval = FV_W'(TRAIL_PATTERN);
            end
            default:
            begin
                flen = IDX_W'(TRAIL_LEN);
                fval = '0;
            end
        endcase
        pos     = flen - IDX_W'(1) - idx_e;
        bit_val = fval[pos[SEL_W-1:0]];
    end

    always_comb
    begin
        sending_next = sending_reg;
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        run_next     = run_reg;
        stuff_next   = stuff_reg;
        key_next     = key_reg;
        addr_next    = addr_reg;
        pay_next     = pay_reg;
        len_next     = len_reg;
        par_next     = par_reg;

        result.line_level    = 1'b1;
        result.busy_res      = 1'b0;
        result.request_taken = taken;
        result.frame_last    = 1'b0;

        if (taken)
        begin
            key_next  = key_e;
            addr_next = addr_e;
            pay_next  = pay_e;
            len_next  = len_e;
            par_next  = par_e;
        end

        if (step && sending_e)
        begin
            result.busy_res = 1'b1;
            sending_next    = 1'b1;
            phase_next      = phase_e;
            idx_next        = idx_e;
            run_next        = run_e;
            stuff_next      = stuff_e;
            if (stuff_e)
            begin
                result.line_level = 1'b0;
                stuff_next        = 1'b0;
            end
            else
            begin
                result.line_level = bit_val;
                idx_next          = idx_e + IDX_W'(1);
                if (bit_val)
                begin
                    run_next = run_e + RUN_W'(1);
                    if (run_next == STUFF_RUN)
                    begin
                        stuff_next = 1'b1;
                        run_next   = '0;
                    end
                end
                else
                begin
                    run_next = '0;
                end
            end
            if (!stuff_next && idx_next >= flen)
            begin
                idx_next = '0;
                run_next = '0;
                if (phase_e == PH_TRAIL)
                begin
                    sending_next      = 1'b0;
                    phase_next        = PH_START;
                    result.frame_last = 1'b1;
                end
                else
                begin
                    phase_next = phase_t'(phase_e + 3'd1);
                    if (phase_next == PH_DATA && len_e == '0)
                    begin
                        phase_next = PH_PAR;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg <= 1'b0;
            phase_reg   <= PH_START;
            idx_reg     <= '0;
            run_reg     <= '0;
            stuff_reg   <= 1'b0;
        end
        else if (step)
        begin
            sending_reg <= sending_next;
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            run_reg     <= run_next;
            stuff_reg   <= stuff_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            key_reg  <= key_next;
            addr_reg <= addr_next;
            pay_reg  <= pay_next;
            len_reg  <= len_next;
            par_reg  <= par_next;
        end
    end

    ap_take: assert property (@(posedge clk) disable iff (!rst_n)
        (step && taken) |=> (sending_reg && phase_reg == PH_START && idx_reg == IDX_W'(1)))
        else $error("frame start did not advance to first start bit");

    ap_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.frame_last) |=> !sending_reg)
        else $error("still sending after last trailer bit");

    ap_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (idx_reg == '0 && run_reg == '0 && !stuff_reg))
        else $error("bit state not cleared while idle");

    ap_stuff: assert property (@(posedge clk) disable iff (!rst_n)
        stuff_reg |-> (run_reg == '0 && sending_reg))
        else $error("stuff bit pending with live ones run");

endmodule

### tb/bit_stuffed_frame_serializer_core_tb.sv
module bit_stuffed_frame_serializer_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bsfs_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int FRAME_TAIL   = 80;
    localparam int BUSY_PROBES  = 20;
    localparam int PHASE_TICKS  = 177;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    in_item_t             in_beat   = '0;
    logic                 pop       = 1'b0;
    logic                 empty;
    out_item_t            out_beat;
    logic                 key_we    = 1'b0;
    logic [KEY_W-1:0]     key_wdata = '0;

    in_item_t             tick_q[$];
    out_item_t            line_expect_q[$];
    int                   errors      = 0;
    int                   idle_cycles = 0;
    int                   in_gap      = 0;
    int                   out_gap     = 0;
    logic                 no_idle     = 1'b0;
    out_item_t            want;

    // serializer shadow state
    logic [KEY_W-1:0]     key_shadow = '0;
    logic                 tx_active  = 1'b0;
    phase_t               tx_phase   = PH_START;
    int                   tx_pos     = 0;
    logic [RUN_W-1:0]     tx_run     = '0;
    logic                 tx_stuff   = 1'b0;
    logic [KEY_W-1:0]     tx_key     = '0;
    logic [ADDR_W-1:0]    tx_addr    = '0;
    logic [PAYLOAD_W-1:0] tx_data    = '0;
    logic [LEN_W-1:0]     tx_len     = '0;
    logic                 tx_parity  = 1'b0;

    bit_stuffed_frame_serializer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (in_beat),
        .pop       (pop),
        .empty     (empty),
        .result    (out_beat),
        .key_we    (key_we),
        .key_wdata (key_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic out_item_t serialize_tick(in_item_t it);
        out_item_t            r;
        logic [PAYLOAD_W-1:0] d;
        logic [PAYLOAD_W-1:0] fval;
        int                   n;
        int                   flen;
        r.line_level    = 1'b1;
        r.busy_res      = 1'b0;
        r.request_taken = 1'b0;
        r.frame_last    = 1'b0;
        if (!tx_active && it.send_request)
        begin
            d = it.payload;
            n = 0;
            for (int i = 0; i < PAYLOAD_W; i++)
            begin
                if (d[i])
                    n = i + 1;
            end
            tx_key = key_shadow;
            if (n <= SHORT_LEN)
                d = (d ^ PAYLOAD_W'(tx_key)) & PAYLOAD_W'(8'hFF);
            tx_parity = 1'b0;
            for (int i = 0; i < n; i++)
                tx_parity ^= d[i];
            tx_data   = d;
            tx_len    = LEN_W'(n);
            tx_addr   = it.dev_address;
            tx_phase  = PH_START;
            tx_pos    = 0;
            tx_run    = '0;
            tx_stuff  = 1'b0;
            tx_active = 1'b1;
            r.request_taken = 1'b1;
        end
        if (tx_active)
        begin
            case (tx_phase)
                PH_START: begin flen = START_LEN;   fval = PAYLOAD_W'(START_PATTERN); end
                PH_KEY:   begin flen = KEY_LEN;     fval = PAYLOAD_W'(tx_key);        end
                PH_ADDR:  begin flen = ADDR_LEN;    fval = PAYLOAD_W'(tx_addr);       end
                PH_LEN:   begin flen = LEN_FIELD_W; fval = PAYLOAD_W'(tx_len);        end
                PH_MARK:  begin flen = MARK_LEN;    fval = PAYLOAD_W'(1);             end
                PH_DATA:  begin flen = int'(tx_len); fval = tx_data;                  end
                PH_PAR:   begin flen = PAR_LEN;     fval = PAYLOAD_W'(tx_parity);     end
                default:  begin flen = TRAIL_LEN;   fval = PAYLOAD_W'(TRAIL_PATTERN); end
            endcase
            r.busy_res = 1'b1;
            if (tx_stuff)
            begin
                r.line_level = 1'b0;
                tx_stuff     = 1'b0;
            end
            else
            begin
                r.line_level = fval[flen - 1 - tx_pos];
                tx_pos++;
                if (r.line_level)
                begin
                    tx_run++;
                    if (tx_run == STUFF_RUN)
                    begin
                        tx_stuff = 1'b1;
                        tx_run   = '0;
                    end
                end
                else
                    tx_run = '0;
            end
            if (!tx_stuff && tx_pos >= flen)
            begin
                tx_pos = 0;
                tx_run = '0;
                if (tx_phase == PH_TRAIL)
                begin
                    tx_active    = 1'b0;
                    tx_phase     = PH_START;
                    r.frame_last = 1'b1;
                end
                else
                begin
                    tx_phase = phase_t'(tx_phase + 3'd1);
                    if (tx_phase == PH_DATA && tx_len == '0)
                        tx_phase = PH_PAR;
                end
            end
        end
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push    <= 1'b0;
            in_beat <= '0;
            in_gap  <= 0;
        end
        else
        begin
            if (push && !full)
                line_expect_q.push_back(serialize_tick(in_beat));
            if (!push || !full)
            begin
                if (in_gap > 0)
                begin
                    push   <= 1'b0;
                    in_gap <= in_gap - 1;
                end
                else if (!no_idle && $urandom_range(0, 9) == 0)
                begin
                    push   <= 1'b0;
                    in_gap <= $urandom_range(0, 6);
                end
                else if (tick_q.size() > 0)
                begin
                    push    <= 1'b1;
                    in_beat <= tick_q.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop         <= 1'b0;
            out_gap     <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (line_expect_q.size() == 0)
                begin
                    errors++;
                    $error("result beat with nothing expected");
                end
                else
                begin
                    want = line_expect_q.pop_front();
                    if (out_beat.line_level !== want.line_level)
                    begin
                        errors++;
                        $error("line_level: expected %0b, got %0b",
                               want.line_level, out_beat.line_level);
                    end
                    if (out_beat.busy_res !== want.busy_res)
                    begin
                        errors++;
                        $error("busy_res: expected %0b, got %0b",
                               want.busy_res, out_beat.busy_res);
                    end
                    if (out_beat.request_taken !== want.request_taken)
                    begin
                        errors++;
                        $error("request_taken: expected %0b, got %0b",
                               want.request_taken, out_beat.request_taken);
                    end
                    if (out_beat.frame_last !== want.frame_last)
                    begin
                        errors++;
                        $error("frame_last: expected %0b, got %0b",
                               want.frame_last, out_beat.frame_last);
                    end
                end
            end
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_gap > 0)
            begin
                pop     <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                pop     <= 1'b0;
                out_gap <= $urandom_range(0, 6);
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_tick(input logic req, input logic [ADDR_W-1:0] addr,
                             input logic [PAYLOAD_W-1:0] data);
        in_item_t it;
        it.send_request = req;
        it.dev_address  = addr;
        it.payload      = data;
        tick_q.push_back(it);
    endtask

    // probe with requests while busy, then let the frame finish
    task automatic push_tail(input int ticks);
        for (int i = 0; i < ticks; i++)
            push_tick(i < BUSY_PROBES ? 1'($urandom_range(0, 1)) : 1'b0,
                      ADDR_W'($urandom), PAYLOAD_W'($urandom));
    endtask

    task automatic queue_frame(input logic [ADDR_W-1:0] addr,
                               input logic [PAYLOAD_W-1:0] data);
        push_tick(1'b1, addr, data);
        push_tail(FRAME_TAIL);
    endtask

    task automatic drain_results();
        while (tick_q.size() != 0 || push || line_expect_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_key(input logic [KEY_W-1:0] k);
        drain_results();
        @(posedge clk);
        key_we    <= 1'b1;
        key_wdata <= k;
        @(posedge clk);
        key_we     <= 1'b0;
        key_shadow  = k;
        @(negedge clk);
    endtask

    task automatic queue_random_tick();
        int                   len;
        logic [PAYLOAD_W-1:0] data;
        logic [ADDR_W-1:0]    addr;
        len = $urandom_range(0, 1) ? $urandom_range(0, SHORT_LEN)
                                   : $urandom_range(SHORT_LEN + 1, PAYLOAD_W);
        data = PAYLOAD_W'($urandom);
        if (len == 0)
            data = '0;
        else
        begin
            if (len < PAYLOAD_W)
                data = data & ((PAYLOAD_W'(1) << len) - 1);
            data[len - 1] = 1'b1;
        end
        addr = ($urandom_range(0, 7) == 0) ? 6'h3F : ADDR_W'($urandom);
        push_tick($urandom_range(0, 4) != 0, addr, data);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_frame(6'h00, 32'h0000_0000);
        write_key(3'd7);
        queue_frame(6'h3F, 32'hFFFF_FFFF);
        queue_frame(6'h0F, 32'h0000_0001);
        queue_frame(6'h2A, 32'h0000_0002);
        queue_frame(6'h15, 32'h0000_0003);
        queue_frame(6'h3C, 32'h0000_0000);
        queue_frame(6'h1E, 32'h0000_7FFF);
        queue_frame(6'h01, 32'h7FFF_FFFF);
        queue_frame(6'h20, 32'h0000_00FF);
        queue_frame(6'h10, 32'h0000_0100);
        queue_frame(6'h3E, 32'h8000_0000);

        // change the key with a frame half sent
        push_tick(1'b1, 6'h33, 32'h0000_00F0);
        repeat (10) push_tick(1'b0, ADDR_W'($urandom), PAYLOAD_W'($urandom));
        write_key(3'd3);
        push_tail(FRAME_TAIL);
        queue_frame(6'h0C, 32'h0000_0005);

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       write_key(3'd0);
                1:       write_key(3'd7);
                default: write_key(KEY_W'($urandom));
            endcase
            if (phase == 4)
                no_idle = 1'b1;
            repeat (PHASE_TICKS) queue_random_tick();
        end

        drain_results();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
